[rtl/hee_pkg.sv]
package hee_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 18;

  localparam int COEF_W    = 20;
  localparam int GAIN_W    = 16;
  localparam int OUT_W     = 18;
  localparam int LVL_W     = 35;
  localparam int DIFF_LO_W = 18;
  localparam int DIFF_HI_W = LVL_W - DIFF_LO_W;

  localparam int IN_TD_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TD_W = ((OUT_W + 2 * LVL_W + 7) / 8) * 8;

  localparam int MA_W  = COEF_W + 1;
  localparam int MB_W  = ((SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W) + 1;
  localparam int PW    = MA_W + MB_W;
  localparam int ACC_W = LVL_W + GAIN_W + 1;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = 5;
  localparam int PC_W     = 5;

  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(64'd1 << (2 * (OUT_W - 1)));

  typedef enum logic [2:0] {
    R_B0, R_B1, R_B2, R_A1, R_A2, R_ATTACK, R_RELEASE, R_FALL
  } reg_e;

  typedef enum logic [3:0] {
    M_NONE, M_B0X, M_B1P1, M_B2P2, M_A1Y1, M_A2Y2, M_SQ, M_GLO, M_GHI
  } msel_e;

  typedef enum logic {G_ENV, G_FALL} gsel_e;

  typedef enum logic [2:0] {A_NONE, A_LOAD, A_ADD, A_SUB, A_ADDHI} aop_e;

  typedef enum logic [2:0] {X_NONE, X_SAT, X_EDIFF, X_ENV, X_PEAK} act_e;

  typedef enum logic [1:0] {J_NEXT, J_RISE, J_END} jmp_e;

  typedef struct packed {
    msel_e            msel;
    gsel_e            gsel;
    aop_e             aop;
    act_e             act;
    jmp_e             jmp;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic cond;
    logic hold;
  } stat_t;

  localparam ctrl_t CTRL_NOP = '{M_NONE, G_ENV, A_NONE, X_NONE, J_NEXT, '0};

  // The product of the step before is what the accumulator sees.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      5'd0:  c.msel = M_B0X;
      5'd1:  begin c.msel = M_B1P1; c.aop = A_LOAD; end
      5'd2:  begin c.msel = M_B2P2; c.aop = A_ADD;  end
      5'd3:  begin c.msel = M_A1Y1; c.aop = A_ADD;  end
      5'd4:  begin c.msel = M_A2Y2; c.aop = A_SUB;  end
      5'd5:  c.aop = A_SUB;
      5'd6:  c.act = X_SAT;
      5'd7:  c.msel = M_SQ;
      5'd8:  c.act = X_EDIFF;
      5'd9:  c.msel = M_GLO;
      5'd10: begin c.msel = M_GHI; c.aop = A_LOAD; end
      5'd11: c.aop = A_ADDHI;
      5'd12: begin c.act = X_ENV; c.jmp = J_RISE; c.target = 5'd16; end
      5'd13: begin c.msel = M_GLO; c.gsel = G_FALL; end
      5'd14: begin c.msel = M_GHI; c.gsel = G_FALL; c.aop = A_LOAD; end
      5'd15: c.aop = A_ADDHI;
      5'd16: begin c.act = X_PEAK; c.jmp = J_END; end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

[rtl/hee_seq.sv]
module hee_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hee_pkg::stat_t  stat_i,
  output hee_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);
  import hee_pkg::*;

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;

  assign word   = ucode(pc_q);
  assign ctrl_o = busy_q ? word : CTRL_NOP;
  assign busy_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (stat_i.start) begin
        busy_d = 1'b1;
        pc_d   = '0;
      end
    end else begin
      unique case (word.jmp)
        J_NEXT: pc_d = pc_q + 1'b1;
        J_RISE: pc_d = stat_i.cond ? word.target : pc_q + 1'b1;
        J_END: begin
          if (!stat_i.hold) begin
            busy_d = 1'b0;
          end
        end
        default: pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

[rtl/highpass_energy_envelope.sv]
// The result is loaded into the output register at the program's last step; when the
// envelope passes the peak, the program skips the peak decay steps and jumps to it.
// A new item is taken only once the program has ended; a microcoded program of up to
// 17 steps drives one shared 21x19 multiplier and a 52-bit accumulator, one step per
// cycle, but a stalled result holds the last step until the output is taken.
// A new item is taken while the previous result still waits in the output register.
// Reset clears the filter history, envelope and peak to zero and loads the
// registers with their default coefficients and gains.
module highpass_energy_envelope (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample
  input  logic [hee_pkg::IN_TD_W-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // filtered, energy_level, peak_level
  output logic [hee_pkg::OUT_TD_W-1:0]      m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hee_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import hee_pkg::*;

  logic signed [COEF_W-1:0] coef_q [5];
  logic [GAIN_W-1:0]        att_q, rel_q, fall_q;

  logic signed [SAMPLE_BITS-1:0] x_q, p1_q, p2_q;
  logic signed [OUT_W-1:0]       y1_q, y2_q;
  logic [LVL_W-1:0]              env_q, peak_q, diff_q;
  logic                          rise_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [ACC_W-1:0]       acc_q;

  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_y_q;
  logic [LVL_W-1:0]      out_env_q, out_peak_q;

  ctrl_t ctrl;
  stat_t stat;
  logic  busy;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic [GAIN_W-1:0]       gain;
  logic [OUT_W-1:0]        mag;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [OUT_W-1:0] y_sat;
  logic [LVL_W-1:0]        energy, step_v, env_new, peak_new;
  logic                    env_gt;
  logic                    hold, wr_en;
  reg_e                    widx;

  localparam int SAT_LO = COEF_FRAC_BITS + OUT_W - 1;

  assign s_axis_tready = !busy;
  assign hold          = out_valid_q && !m_axis_tready;

  assign stat.start = s_axis_tvalid && s_axis_tready;
  assign stat.cond  = env_gt;
  assign stat.hold  = hold;

  hee_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  assign gain = (ctrl.gsel == G_FALL) ? fall_q : (rise_q ? att_q : rel_q);
  assign mag  = y1_q[OUT_W-1] ? (~y1_q + 1'b1) : y1_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.msel)
      M_B0X:  begin mul_a = MA_W'(coef_q[0]); mul_b = MB_W'(x_q);  end
      M_B1P1: begin mul_a = MA_W'(coef_q[1]); mul_b = MB_W'(p1_q); end
      M_B2P2: begin mul_a = MA_W'(coef_q[2]); mul_b = MB_W'(p2_q); end
      M_A1Y1: begin mul_a = MA_W'(coef_q[3]); mul_b = MB_W'(y1_q); end
      M_A2Y2: begin mul_a = MA_W'(coef_q[4]); mul_b = MB_W'(y2_q); end
      M_SQ: begin
        mul_a = $signed({{(MA_W-OUT_W){1'b0}}, mag});
        mul_b = $signed({{(MB_W-OUT_W){1'b0}}, mag});
      end
      M_GLO: begin
        mul_a = $signed({{(MA_W-GAIN_W){1'b0}}, gain});
        mul_b = $signed({{(MB_W-DIFF_LO_W){1'b0}}, diff_q[DIFF_LO_W-1:0]});
      end
      M_GHI: begin
        mul_a = $signed({{(MA_W-GAIN_W){1'b0}}, gain});
        mul_b = $signed({{(MB_W-DIFF_HI_W){1'b0}}, diff_q[LVL_W-1:DIFF_LO_W]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};

  always_comb begin
    if (&acc_q[ACC_W-1:SAT_LO] || !(|acc_q[ACC_W-1:SAT_LO])) begin
      y_sat = acc_q[SAT_LO:COEF_FRAC_BITS];
    end else if (acc_q[ACC_W-1]) begin
      y_sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  assign energy   = prod_q[LVL_W-1:0];
  assign step_v   = acc_q[GAIN_W+LVL_W-1:GAIN_W];
  assign env_new  = rise_q ? (env_q + step_v) : (env_q - step_v);
  assign env_gt   = (ctrl.act == X_ENV) && (env_new > peak_q);
  assign peak_new = rise_q ? env_q : (peak_q - step_v);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (stat.start) begin
      x_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    case (ctrl.aop)
      A_LOAD:  acc_q <= prod_ext;
      A_ADD:   acc_q <= acc_q + prod_ext;
      A_SUB:   acc_q <= acc_q - prod_ext;
      A_ADDHI: acc_q <= acc_q + (prod_ext <<< DIFF_LO_W);
      default: acc_q <= acc_q;
    endcase
    case (ctrl.act)
      X_EDIFF: begin
        rise_q <= energy > env_q;
        diff_q <= (energy > env_q) ? (energy - env_q) : (env_q - energy);
      end
      X_ENV: begin
        rise_q <= env_gt;
        diff_q <= peak_q;
      end
      default: begin
        rise_q <= rise_q;
        diff_q <= diff_q;
      end
    endcase
  end

  assign wr_en = psel && penable && pwrite;
  assign widx  = reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0]   <= COEF_W'(262144);
      coef_q[1]   <= '0;
      coef_q[2]   <= '0;
      coef_q[3]   <= '0;
      coef_q[4]   <= '0;
      att_q       <= GAIN_W'(3971);
      rel_q       <= GAIN_W'(408);
      fall_q      <= GAIN_W'(82);
      p1_q        <= '0;
      p2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      env_q       <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
      out_y_q     <= '0;
      out_env_q   <= '0;
      out_peak_q  <= '0;
    end else begin
      if (wr_en) begin
        unique case (widx)
          R_B0:      coef_q[0] <= pwdata[COEF_W-1:0];
          R_B1:      coef_q[1] <= pwdata[COEF_W-1:0];
          R_B2:      coef_q[2] <= pwdata[COEF_W-1:0];
          R_A1:      coef_q[3] <= pwdata[COEF_W-1:0];
          R_A2:      coef_q[4] <= pwdata[COEF_W-1:0];
          R_ATTACK:  att_q     <= pwdata[GAIN_W-1:0];
          R_RELEASE: rel_q     <= pwdata[GAIN_W-1:0];
          R_FALL:    fall_q    <= pwdata[GAIN_W-1:0];
          default:   att_q     <= att_q;
        endcase
      end
      if (ctrl.act == X_SAT) begin
        p2_q <= p1_q;
        p1_q <= x_q;
        y2_q <= y1_q;
        y1_q <= y_sat;
      end
      if (ctrl.act == X_ENV) begin
        env_q <= env_new;
      end
      if (ctrl.act == X_PEAK && !hold) begin
        peak_q      <= peak_new;
        out_valid_q <= 1'b1;
        out_y_q     <= y1_q;
        out_env_q   <= env_q;
        out_peak_q  <= peak_new;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (widx)
      R_B0:      prdata = 32'(coef_q[0]) & 32'((64'd1 << COEF_W) - 1);
      R_B1:      prdata = 32'(coef_q[1]) & 32'((64'd1 << COEF_W) - 1);
      R_B2:      prdata = 32'(coef_q[2]) & 32'((64'd1 << COEF_W) - 1);
      R_A1:      prdata = 32'(coef_q[3]) & 32'((64'd1 << COEF_W) - 1);
      R_A2:      prdata = 32'(coef_q[4]) & 32'((64'd1 << COEF_W) - 1);
      R_ATTACK:  prdata = 32'(att_q);
      R_RELEASE: prdata = 32'(rel_q);
      R_FALL:    prdata = 32'(fall_q);
      default:   prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TD_W'({out_peak_q, out_env_q, out_y_q});

endmodule

[rtl/hee_checker.sv]
module hee_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hee_pkg::OUT_TD_W-1:0]  m_axis_tdata
);
  import hee_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken again right after an item");

  a_program_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##14 !s_axis_tready)
    else $error("item finished before the shortest program ran out");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item at work");

  a_levels_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_W+LVL_W-1:OUT_W] <= LVL_MAX) &&
                      (m_axis_tdata[OUT_W+2*LVL_W-1:OUT_W+LVL_W] <= LVL_MAX))
    else $error("energy or peak level out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind highpass_energy_envelope hee_checker u_hee_checker (.*);
